>>> rtl/ero_pkg.sv
// Shared types, constants and arithmetic helpers of the Euler rotation matrix block.
package ero_pkg;

  localparam int CordicStagesDef = 16;
  localparam int OutFracBitsDef  = 14;
  localparam int TableLen        = 24;
  localparam int WorkFrac        = 30;
  localparam int XW              = 34;
  localparam int ZW              = 32;
  localparam int TW              = 32;
  localparam int PW              = 34;

  localparam logic signed [16:0] TurnUnits    = 17'sd23040;
  localparam logic signed [16:0] HalfTurn     = 17'sd11520;
  localparam logic signed [16:0] QuarterTurn  = 17'sd5760;
  localparam logic signed [XW-1:0] GainQ30    = XW'(652032874);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } lane_t;

  typedef struct packed {
    logic signed [TW-1:0] sx;
    logic signed [TW-1:0] cx;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sz;
    logic signed [TW-1:0] cz;
  } trig_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 32'sd188743680;
      1:  v = 32'sd111421900;
      2:  v = 32'sd58872272;
      3:  v = 32'sd29884485;
      4:  v = 32'sd15000234;
      5:  v = 32'sd7507429;
      6:  v = 32'sd3754631;
      7:  v = 32'sd1877430;
      8:  v = 32'sd938729;
      9:  v = 32'sd469366;
      10: v = 32'sd234683;
      11: v = 32'sd117342;
      12: v = 32'sd58671;
      13: v = 32'sd29335;
      14: v = 32'sd14668;
      15: v = 32'sd7334;
      16: v = 32'sd3667;
      17: v = 32'sd1833;
      18: v = 32'sd917;
      19: v = 32'sd458;
      20: v = 32'sd229;
      21: v = 32'sd115;
      22: v = 32'sd57;
      23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Folds an angle into [-90, 90] degrees and sets up the first CORDIC vector.
  function automatic lane_t reduce_angle(input logic signed [15:0] a);
    logic signed [16:0] r;
    lane_t l;
    r = 17'(a);
    if (r < 0) r = r + TurnUnits;
    if (r < 0) r = r + TurnUnits;
    if (r >= TurnUnits) r = r - TurnUnits;
    if (r >= HalfTurn) r = r - TurnUnits;
    l.flip = 1'b0;
    if (r > QuarterTurn) begin
      r = r - HalfTurn;
      l.flip = 1'b1;
    end else if (r < -QuarterTurn) begin
      r = r + HalfTurn;
      l.flip = 1'b1;
    end
    l.x = GainQ30;
    l.y = '0;
    l.z = ZW'(r) <<< 16;
    return l;
  endfunction

  function automatic logic signed [PW-1:0] mul_q30(input logic signed [TW-1:0] a,
                                                    input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b + (64'sd1 <<< (WorkFrac - 1));
    return PW'(p >>> WorkFrac);
  endfunction

endpackage

>>> rtl/ero_cell.sv
// One CORDIC rotation step for the three angle lanes, with its pipeline register.
module ero_cell
  import ero_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  lane_t [2:0]     lane_i,
  output logic            valid_o,
  output lane_t [2:0]     lane_o
);

  lane_t [2:0] lane_d, lane_q;
  logic        valid_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_d[k].flip = lane_i[k].flip;
      if (lane_i[k].z >= 0) begin
        lane_d[k].x = lane_i[k].x - (lane_i[k].y >>> STAGE);
        lane_d[k].y = lane_i[k].y + (lane_i[k].x >>> STAGE);
        lane_d[k].z = lane_i[k].z - atan_deg(STAGE);
      end else begin
        lane_d[k].x = lane_i[k].x + (lane_i[k].y >>> STAGE);
        lane_d[k].y = lane_i[k].y - (lane_i[k].x >>> STAGE);
        lane_d[k].z = lane_i[k].z + atan_deg(STAGE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

>>> rtl/ero_matrix.sv
// Products, sums, rounding and saturation that turn sines and cosines into the matrix.
module ero_matrix
  import ero_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OutFracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  trig_t         trig_i,
  output logic          valid_o,
  output logic [143:0]  data_o
);

  localparam int Sh = WorkFrac - OUT_FRAC_BITS;
  localparam logic signed [PW-1:0] RoundAdd = (Sh > 0) ? (PW'(1) <<< (Sh - 1)) : '0;
  localparam logic signed [PW-1:0] Lim      = PW'(1) <<< OUT_FRAC_BITS;

  logic signed [PW-1:0] sxsy_q, cxsy_q, cycz_q, cysz_q, cxsz_q, cxcz_q;
  logic signed [PW-1:0] sxcy_q, sxsz_q, cxcy_q, sxcz_q;
  logic signed [TW-1:0] sy_q, sz_q, cz_q;
  logic signed [PW-1:0] e_d [9];
  logic signed [PW-1:0] e_q [9];
  logic [143:0]         data_d, data_q;
  logic [2:0]           valid_q;

  function automatic logic [15:0] to_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + RoundAdd) >>> Sh;
    if (r > Lim) r = Lim;
    if (r < -Lim) r = -Lim;
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sxsy_q <= mul_q30(trig_i.sx, trig_i.sy);
      cxsy_q <= mul_q30(trig_i.cx, trig_i.sy);
      cycz_q <= mul_q30(trig_i.cy, trig_i.cz);
      cysz_q <= mul_q30(trig_i.cy, trig_i.sz);
      cxsz_q <= mul_q30(trig_i.cx, trig_i.sz);
      cxcz_q <= mul_q30(trig_i.cx, trig_i.cz);
      sxcy_q <= mul_q30(trig_i.sx, trig_i.cy);
      sxsz_q <= mul_q30(trig_i.sx, trig_i.sz);
      cxcy_q <= mul_q30(trig_i.cx, trig_i.cy);
      sxcz_q <= mul_q30(trig_i.sx, trig_i.cz);
      sy_q   <= trig_i.sy;
      sz_q   <= trig_i.sz;
      cz_q   <= trig_i.cz;
    end
  end

  always_comb begin
    e_d[0] = cycz_q;
    e_d[1] = -cysz_q;
    e_d[2] = PW'(sy_q);
    e_d[3] = mul_q30(TW'(sxsy_q), cz_q) + cxsz_q;
    e_d[4] = cxcz_q - mul_q30(TW'(sxsy_q), sz_q);
    e_d[5] = -sxcy_q;
    e_d[6] = sxsz_q - mul_q30(TW'(cxsy_q), cz_q);
    e_d[7] = mul_q30(TW'(cxsy_q), sz_q) + sxcz_q;
    e_d[8] = cxcy_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      data_d[16*k +: 16] = to_out(e_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign valid_o = valid_q[2];
  assign data_o  = data_q;

endmodule

>>> rtl/euler_rotation_matrix.sv
// Top level: angle folding, a chain of CORDIC cells and the matrix product pipeline.
//
//  Channel  Direction  Width  Contents
//  s_axis   in         48     angle_x, angle_y, angle_z
//  m_axis   out        144    m00 .. m22 in row order
//
// Every cycle a beat can enter while m_axis is not stalled; the pipeline holds
// one fold stage, one per CORDIC cell, two product stages and the output register.
// The whole pipeline advances together whenever the output register is empty or taken.
// A stall on m_axis holds every stage and drops s_axis_tready in the same cycle.
// Reset clears only the valid bits of the stages.
module euler_rotation_matrix
  import ero_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef,
  parameter int OUT_FRAC_BITS = OutFracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,   // angle_x, angle_y, angle_z
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  localparam int NCells = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;

  logic        en;
  lane_t [2:0] chain_lane [NCells+1];
  logic        chain_valid [NCells+1];
  lane_t [2:0] fold_d, fold_q;
  logic        fold_valid_q;
  trig_t       trig;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fold_d[k] = reduce_angle(s_axis_tdata[16*k +: 16]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else if (en) begin
      fold_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fold_q <= fold_d;
    end
  end

  assign chain_lane[0]  = fold_q;
  assign chain_valid[0] = fold_valid_q;

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    ero_cell #(.STAGE(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .lane_i  (chain_lane[g]),
      .valid_o (chain_valid[g+1]),
      .lane_o  (chain_lane[g+1])
    );
  end

  function automatic logic signed [TW-1:0] fin(input logic signed [XW-1:0] v,
                                               input logic f);
    return f ? TW'(-v) : TW'(v);
  endfunction

  always_comb begin
    trig.sx = fin(chain_lane[NCells][0].y, chain_lane[NCells][0].flip);
    trig.cx = fin(chain_lane[NCells][0].x, chain_lane[NCells][0].flip);
    trig.sy = fin(chain_lane[NCells][1].y, chain_lane[NCells][1].flip);
    trig.cy = fin(chain_lane[NCells][1].x, chain_lane[NCells][1].flip);
    trig.sz = fin(chain_lane[NCells][2].y, chain_lane[NCells][2].flip);
    trig.cz = fin(chain_lane[NCells][2].x, chain_lane[NCells][2].flip);
  end

  ero_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[NCells]),
    .trig_i  (trig),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

  localparam logic signed [16:0] OutLim = 17'(1 << ((OUT_FRAC_BITS > 15) ? 15 : OUT_FRAC_BITS));

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output register");

  a_m02_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && OUT_FRAC_BITS <= 14) |->
      ($signed({m_axis_tdata[47], m_axis_tdata[47:32]}) <= OutLim &&
       $signed({m_axis_tdata[47], m_axis_tdata[47:32]}) >= -OutLim))
    else $error("m02 outside saturation range");

  a_m22_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && OUT_FRAC_BITS <= 14) |->
      ($signed({m_axis_tdata[143], m_axis_tdata[143:128]}) <= OutLim &&
       $signed({m_axis_tdata[143], m_axis_tdata[143:128]}) >= -OutLim))
    else $error("m22 outside saturation range");

endmodule
